[sv/pnorm_pkg.sv]
// Shared types and constants of the peak normaliser.
`default_nettype none

package pnorm_pkg;

    // Opcodes carried by an input word
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Status codes of a result word
    localparam int unsigned STAT_W = 2;
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PEAK_ZERO = 2'd2;

    // Output scale: the peak maps to 2^FS_BITS - 1
    localparam int unsigned FS_BITS = 15;
    localparam int unsigned OUT_W   = 16;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_DIV,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[sv/pnorm_in_if.sv]
// Input channel: valid/ready handshake carrying one load or read request word.
`default_nettype none

interface pnorm_in_if #(
    parameter int unsigned SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first_of_trace;

    modport source (
        output valid, opcode, sample, first_of_trace,
        input  ready
    );

    modport sink (
        input  valid, opcode, sample, first_of_trace,
        output ready
    );
endinterface

`default_nettype wire

[sv/pnorm_out_if.sv]
// Output channel: valid/ready handshake carrying one scaled result word.
`default_nettype none

interface pnorm_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [pnorm_pkg::OUT_W-1:0]       scaled_value;
    logic                                     last_of_trace;
    logic        [pnorm_pkg::STAT_W-1:0]      status;
    logic                                     overflowed;

    modport source (
        output valid, scaled_value, last_of_trace, status, overflowed,
        input  ready
    );

    modport sink (
        input  valid, scaled_value, last_of_trace, status, overflowed,
        output ready
    );
endinterface

`default_nettype wire

[sv/pnorm_store.sv]
// Single-port-write, registered-read sample memory.
`default_nettype none

module pnorm_store #(
    parameter int unsigned DEPTH  = 4096,
    parameter int unsigned WIDTH  = 24,
    parameter int unsigned ADDR_W = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/pnorm_div.sv]
// Radix-2 restoring divider: floor(mag * (2^FS_BITS - 1) / divisor), mag <= divisor.
`default_nettype none

module pnorm_div #(
    parameter int unsigned MAG_W = 23
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [MAG_W-1:0]                i_mag,
    input  wire logic [MAG_W-1:0]                i_divisor,
    output logic                                 o_done,
    output logic      [pnorm_pkg::FS_BITS-1:0]   o_quot
);

    localparam int unsigned FSB   = pnorm_pkg::FS_BITS;
    localparam int unsigned NUM_W = MAG_W + FSB;
    localparam int unsigned CNT_W = $clog2(FSB + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [MAG_W-1:0] r_rem;
    logic [FSB-1:0]   r_low;
    logic [FSB-1:0]   r_quot;

    logic [MAG_W:0]   w_trial;
    logic             w_ge;
    logic [MAG_W:0]   w_diff;

    // One quotient bit per step: shift in the next dividend bit, compare, subtract
    assign w_trial = {r_rem, r_low[FSB-1]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(FSB)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the product mag*(2^FSB - 1) is a shift and a subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_mag, {FSB{1'b0}}} - {{FSB{1'b0}}, i_mag};
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                // top part is below the divisor since the quotient fits FSB bits
                r_rem <= r_num[NUM_W-1:FSB];
                r_low <= r_num[FSB-1:0];
            end else begin
                r_rem  <= w_ge ? w_diff[MAG_W-1:0] : w_trial[MAG_W-1:0];
                r_low  <= {r_low[FSB-2:0], 1'b0};
                r_quot <= {r_quot[FSB-2:0], w_ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

[sv/peak_normalize_to_int16.sv]
// Top level: trace store with running peak, and scaled read-back through a single divider.
//
// On a load word the sample (most negative code clamped) is written
// to the store and the running peak of magnitudes is updated; loads past
// MAX_SAMPLES are dropped and set the overflow flag. A read word goes through
// the registered memory read, the start of the divider, the radix-2 restoring
// divider that forms trunc(32767 * |sample| / peak), and the hand-over of
// the word to the output register. A read with nothing left, or of an
// all-zero trace, skips the divider and goes straight to the hand-over. The input
// is not ready while a read is under way; the output register lets the next
// word in while a result still waits to be taken. No clearing pass after reset.
`default_nettype none

module peak_normalize_to_int16 #(
    parameter int unsigned MAX_SAMPLES = 4096,
    parameter int unsigned SAMPLE_BITS = 24
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    pnorm_in_if.sink     i_in,
    pnorm_out_if.source  o_out
);

    localparam int unsigned MAG_W  = SAMPLE_BITS - 1;
    localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned ADDR_W = $clog2(MAX_SAMPLES);
    localparam int unsigned OUT_W  = pnorm_pkg::OUT_W;
    localparam int unsigned STAT_W = pnorm_pkg::STAT_W;
    localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {MAG_W{1'b0}}};

    // Sequencer and trace state
    pnorm_pkg::t_state r_state, n_state;
    logic [MAG_W-1:0]  r_peak, n_peak;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_rdpos, n_rdpos;
    logic              r_ovf, n_ovf;
    logic              r_neg, n_neg;

    // Pending result word
    logic [OUT_W-1:0]  r_res_value, n_res_value;
    logic              r_res_last, n_res_last;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic              r_res_ovf, n_res_ovf;

    // Output register
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_value;
    logic              r_out_last;
    logic [STAT_W-1:0] r_out_status;
    logic              r_out_ovf;

    logic                   w_accept;
    logic                   w_is_read;
    logic [SAMPLE_BITS-1:0] w_samp;
    logic [SAMPLE_BITS-1:0] w_abs;
    logic [CNT_W-1:0]       w_base_cnt;
    logic [MAG_W-1:0]       w_base_peak;
    logic                   w_full;
    logic                   w_empty;
    logic [CNT_W-1:0]       w_rdpos_inc;
    logic                   w_wr_en;
    logic                   w_rd_en;
    logic [SAMPLE_BITS-1:0] w_rd_data;
    logic [SAMPLE_BITS-1:0] w_rd_abs;
    logic                   w_ready;
    logic                   w_div_start;
    logic                   w_out_load;
    logic                   w_div_done;
    logic [pnorm_pkg::FS_BITS-1:0] w_quot;
    logic [OUT_W-1:0]       w_q16;

    assign w_accept  = i_in.valid && w_ready;
    assign w_is_read = (i_in.opcode == pnorm_pkg::OP_READ);

    // Load path: clamp, magnitude, store position
    assign w_samp      = (i_in.sample == MOST_NEG) ? MOST_NEG + SAMPLE_BITS'(1)
                                                   : i_in.sample;
    assign w_abs       = w_samp[SAMPLE_BITS-1] ? (~w_samp + SAMPLE_BITS'(1)) : w_samp;
    assign w_base_cnt  = i_in.first_of_trace ? '0 : r_count;
    assign w_base_peak = i_in.first_of_trace ? '0 : r_peak;
    assign w_full      = (w_base_cnt == CNT_W'(MAX_SAMPLES));
    assign w_wr_en     = w_accept && !w_is_read && !w_full;

    // Read path
    assign w_empty     = (r_rdpos >= r_count);
    assign w_rdpos_inc = r_rdpos + CNT_W'(1);
    assign w_rd_en     = w_accept && w_is_read && !w_empty;
    assign w_rd_abs    = w_rd_data[SAMPLE_BITS-1] ? (~w_rd_data + SAMPLE_BITS'(1))
                                                  : w_rd_data;
    assign w_q16       = {{(OUT_W - pnorm_pkg::FS_BITS){1'b0}}, w_quot};

    pnorm_store #(
        .DEPTH  (MAX_SAMPLES),
        .WIDTH  (SAMPLE_BITS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_base_cnt[ADDR_W-1:0]),
        .i_wr_data (w_samp),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rdpos[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    pnorm_div #(
        .MAG_W (MAG_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_mag     (w_rd_abs[MAG_W-1:0]),
        .i_divisor (r_peak),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pnorm_pkg::S_IDLE: begin
                if (w_accept && w_is_read) begin
                    if (w_empty || r_peak == '0) begin
                        n_state = pnorm_pkg::S_DONE;
                    end else begin
                        n_state = pnorm_pkg::S_FETCH;
                    end
                end
            end
            pnorm_pkg::S_FETCH: begin
                n_state = pnorm_pkg::S_DIV;
            end
            pnorm_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = pnorm_pkg::S_DONE;
                end
            end
            pnorm_pkg::S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = pnorm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pnorm_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_ready     = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            pnorm_pkg::S_IDLE:  w_ready     = 1'b1;
            pnorm_pkg::S_FETCH: w_div_start = 1'b1;
            pnorm_pkg::S_DONE:  w_out_load  = !r_out_valid || o_out.ready;
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    // Trace state and pending result
    always_comb begin
        n_peak       = r_peak;
        n_count      = r_count;
        n_rdpos      = r_rdpos;
        n_ovf        = r_ovf;
        n_neg        = r_neg;
        n_res_value  = r_res_value;
        n_res_last   = r_res_last;
        n_res_status = r_res_status;
        n_res_ovf    = r_res_ovf;

        if (w_accept && !w_is_read) begin
            // load word
            if (i_in.first_of_trace) begin
                n_rdpos = '0;
            end
            if (w_full) begin
                n_count = w_base_cnt;
                n_peak  = w_base_peak;
                n_ovf   = 1'b1;
            end else begin
                n_count = w_base_cnt + CNT_W'(1);
                n_peak  = (w_abs[MAG_W-1:0] > w_base_peak) ? w_abs[MAG_W-1:0]
                                                           : w_base_peak;
                n_ovf   = i_in.first_of_trace ? 1'b0 : r_ovf;
            end
        end else if (w_accept) begin
            // read word: everything but the quotient is known now
            n_res_value = '0;
            n_res_ovf   = r_ovf;
            if (w_empty) begin
                n_res_last   = 1'b0;
                n_res_status = pnorm_pkg::STAT_EMPTY;
            end else begin
                n_rdpos      = w_rdpos_inc;
                n_res_last   = (w_rdpos_inc == r_count);
                n_res_status = (r_peak == '0) ? pnorm_pkg::STAT_PEAK_ZERO
                                              : pnorm_pkg::STAT_OK;
            end
        end

        if (r_state == pnorm_pkg::S_FETCH) begin
            n_neg = w_rd_data[SAMPLE_BITS-1];
        end

        if (w_div_done) begin
            n_res_value = r_neg ? (~w_q16 + OUT_W'(1)) : w_q16;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pnorm_pkg::S_IDLE;
            r_peak      <= '0;
            r_count     <= '0;
            r_rdpos     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_peak  <= n_peak;
            r_count <= n_count;
            r_rdpos <= n_rdpos;
            r_ovf   <= n_ovf;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_neg        <= n_neg;
        r_res_value  <= n_res_value;
        r_res_last   <= n_res_last;
        r_res_status <= n_res_status;
        r_res_ovf    <= n_res_ovf;
        if (w_out_load) begin
            r_out_value  <= r_res_value;
            r_out_last   <= r_res_last;
            r_out_status <= r_res_status;
            r_out_ovf    <= r_res_ovf;
        end
    end

    assign i_in.ready          = w_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.scaled_value  = r_out_value;
    assign o_out.last_of_trace = r_out_last;
    assign o_out.status        = r_out_status;
    assign o_out.overflowed    = r_out_ovf;

endmodule

`default_nettype wire
